// File: rtl/sdf_pkg.sv
`default_nettype none
package sdf_pkg;

  // Width of the value field on both channels
  localparam int SDF_DATA_W = 32;

  // Defaults for the top-level parameters
  localparam int SDF_TABLE_DEPTH = 64;
  localparam int SDF_VALUE_WIDTH = 32;

endpackage
`default_nettype wire

// File: rtl/sdf_in_if.sv
`default_nettype none
interface sdf_in_if;
  import sdf_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [SDF_DATA_W-1:0] value;
  logic                         last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);

endinterface
`default_nettype wire

// File: rtl/sdf_out_if.sv
`default_nettype none
interface sdf_out_if;
  import sdf_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [SDF_DATA_W-1:0] value_out;
  logic                         keep;
  logic                         overflow;
  logic                         last_out;

  modport source (output valid, output value_out, output keep, output overflow,
                  output last_out, input ready);
  modport sink   (input valid, input value_out, input keep, input overflow,
                  input last_out, output ready);

endinterface
`default_nettype wire

// File: rtl/sdf_seen_ram.sv
`default_nettype none
// One write port, one read port, registered read data.
module sdf_seen_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/stream_distinct_filter.sv
`default_nettype none
// Duplicate filter for a stream of lists. Each item (value, last) gets one
// result (value_out, keep, overflow, last_out): keep is 1 for the first
// occurrence of a value within the current list and 0 for a repeat. Values
// are matched on their low VALUE_WIDTH bits against a table of up to
// TABLE_DEPTH values held in a single-port-read RAM; when the table is full a
// new value is kept but not stored and overflow is set. The item flagged last
// empties the table for the next list. Items are handled one at a time.
// The RAM scan compares one stored entry per cycle, and a match ends the
// scan early. The next item can be accepted in the cycle after the result
// is loaded. A result waiting in the output register does not block the
// next accept; only loading a new result waits for it. No clearing pass
// is needed after reset.
module stream_distinct_filter
  import sdf_pkg::*;
#(
  parameter int TABLE_DEPTH = SDF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = SDF_VALUE_WIDTH
) (
  input wire logic   clk,
  input wire logic   rst_n,
  sdf_in_if.sink     in_ch,
  sdf_out_if.source  out_ch
);

  // Table address and fill count widths
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // Sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_r, state_nxt;

  // Item under work
  logic signed [SDF_DATA_W-1:0] value_r;
  logic [VALUE_WIDTH-1:0]       key_r;
  logic                         last_r;
  logic                         found_r, found_nxt;

  // Fill count and scan pointer
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;

  // Output register
  logic                         out_valid_r;
  logic signed [SDF_DATA_W-1:0] value_out_r;
  logic                         keep_r;
  logic                         ovf_r;
  logic                         last_out_r;

  logic [VALUE_WIDTH-1:0] in_key;
  logic                   in_fire;
  logic                   out_free;
  logic                   hit;
  logic                   scan_end;
  logic                   table_full;
  logic                   do_load;
  logic                   do_store;

  // RAM ports
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  // Compare key: low VALUE_WIDTH bits, zero-extended when wider than the field
  generate
    if (VALUE_WIDTH <= SDF_DATA_W) begin : g_key_trunc
      assign in_key = in_ch.value[VALUE_WIDTH-1:0];
    end else begin : g_key_ext
      assign in_key = {{(VALUE_WIDTH - SDF_DATA_W){1'b0}}, in_ch.value};
    end
  endgenerate

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // RAM data in SCAN belongs to entry idx_r, read the cycle before
  assign hit        = (ram_rdata == key_r);
  assign scan_end   = ((CW'(idx_r) + CW'(1)) == count_r);
  assign table_full = (count_r == CW'(TABLE_DEPTH));

  // Reads: entry 0 on accept, next entry while the scan goes on
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state_r)
      ST_IDLE: begin
        ram_re    = in_fire;
        ram_raddr = '0;
      end
      ST_SCAN: begin
        ram_re    = !hit && !scan_end;
        ram_raddr = idx_r + AW'(1);
      end
      default: begin
        ram_re    = 1'b0;
        ram_raddr = '0;
      end
    endcase
  end

  assign do_load  = (state_r == ST_FINISH) && out_free;
  assign do_store = do_load && !found_r && !table_full;

  always_comb begin
    state_nxt = state_r;
    found_nxt = found_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          found_nxt = 1'b0;
          idx_nxt   = '0;
          // Empty table: nothing to scan
          state_nxt = (count_r == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          found_nxt = 1'b1;
          state_nxt = ST_FINISH;
        end else if (scan_end) begin
          state_nxt = ST_FINISH;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      ST_FINISH: begin
        if (do_load) begin
          state_nxt = ST_IDLE;
          if (last_r) begin
            count_nxt = '0;
          end else if (do_store) begin
            count_nxt = count_r + CW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      found_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      found_r <= found_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      value_r <= in_ch.value;
      key_r   <= in_key;
      last_r  <= in_ch.last;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (do_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      value_out_r <= value_r;
      keep_r      <= !found_r;
      ovf_r       <= !found_r && table_full;
      last_out_r  <= last_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.value_out = value_out_r;
  assign out_ch.keep      = keep_r;
  assign out_ch.overflow  = ovf_r;
  assign out_ch.last_out  = last_out_r;

  // The store lands in FINISH, before the next accept can start a read,
  // so a read never meets a write to the same entry.
  sdf_seen_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (VALUE_WIDTH),
    .AW    (AW)
  ) u_seen_ram (
    .clk   (clk),
    .we    (do_store),
    .waddr (count_r[AW-1:0]),
    .wdata (key_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

// File: bench/sdf_dedup_checker.sv
`default_nettype none
module sdf_dedup_checker
  import sdf_pkg::*;
#(
  parameter int TABLE_DEPTH = SDF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = SDF_VALUE_WIDTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic                         in_ready,
  input  wire logic signed [SDF_DATA_W-1:0] in_value,
  input  wire logic                         in_last,
  input  wire logic                         out_valid,
  input  wire logic                         out_ready,
  input  wire logic signed [SDF_DATA_W-1:0] out_value_out,
  input  wire logic                         out_keep,
  input  wire logic                         out_overflow,
  input  wire logic                         out_last_out,
  output int                                fail_count,
  output int                                pending,
  output int                                n_kept,
  output int                                n_dropped,
  output int                                n_overflow,
  output int                                n_lists
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] KEY_MASK = (VALUE_WIDTH >= 64) ? {64{1'b1}} :
                                     ((64'd1 << VALUE_WIDTH) - 64'd1);

  typedef struct packed {
    logic signed [SDF_DATA_W-1:0] value_out;
    logic                         keep;
    logic                         overflow;
    logic                         last_out;
  } dedup_result_t;

  dedup_result_t pending_results[$];
  logic [63:0]   seen_keys[TABLE_DEPTH];
  int            seen_cnt;
  int            errors, kept, dropped, overflowed, lists;

  // First-occurrence lookup; updates the seen table like the block does.
  function automatic dedup_result_t classify_value(input logic [SDF_DATA_W-1:0] v,
                                                   input logic l);
    dedup_result_t r;
    logic [63:0]   key;
    logic          found;
    key   = 64'(v) & KEY_MASK;
    found = 1'b0;
    for (int i = 0; i < seen_cnt; i++)
      if (seen_keys[i] == key) found = 1'b1;
    r.value_out = v;
    r.keep      = !found;
    r.overflow  = 1'b0;
    r.last_out  = l;
    if (!found) begin
      if (seen_cnt < TABLE_DEPTH) begin
        seen_keys[seen_cnt] = key;
        seen_cnt++;
      end else begin
        r.overflow = 1'b1;
      end
    end
    if (l) seen_cnt = 0;
    return r;
  endfunction

  initial begin
    seen_cnt   = 0;
    errors     = 0;
    kept       = 0;
    dropped    = 0;
    overflowed = 0;
    lists      = 0;
    fail_count = 0;
    pending    = 0;
    n_kept     = 0;
    n_dropped  = 0;
    n_overflow = 0;
    n_lists    = 0;
  end

  always @(posedge clk) begin : track
    dedup_result_t want;
    if (!rst_n) begin
      seen_cnt = 0;
      pending_results.delete();
    end else begin
      // result side first: a result can never belong to this cycle's item
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: value_out %0d with nothing outstanding", out_value_out);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_value_out !== want.value_out) begin
            $error("value_out: expected %0d, got %0d", want.value_out, out_value_out);
            errors++;
          end
          if (out_keep !== want.keep) begin
            $error("keep: expected %0b, got %0b", want.keep, out_keep);
            errors++;
          end
          if (out_overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, out_overflow);
            errors++;
          end
          if (out_last_out !== want.last_out) begin
            $error("last_out: expected %0b, got %0b", want.last_out, out_last_out);
            errors++;
          end
          if (want.keep) kept++;
          else dropped++;
          if (want.overflow) overflowed++;
          if (want.last_out) lists++;
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(classify_value(in_value, in_last));
    end
    fail_count <= errors;
    pending    <= pending_results.size();
    n_kept     <= kept;
    n_dropped  <= dropped;
    n_overflow <= overflowed;
    n_lists    <= lists;
  end

endmodule
`default_nettype wire

// File: bench/testbench.sv
`default_nettype none
// Stimulus and verdict for the duplicate filter. The checker beside the DUT
// predicts every result; this module only feeds lists of items, throttles
// the result side, and decides pass/fail.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sdf_pkg::*;

  localparam int DEPTH          = SDF_TABLE_DEPTH;
  localparam int ITEM_TARGET    = 900;
  localparam int WATCHDOG_LIMIT = 3000;   // cycles with no handshake at all
  localparam int STEADY_FROM    = 350;    // item window with no idling on
  localparam int STEADY_TO      = 520;    // either side

  // Kinds of random list the generator picks from.
  typedef enum int {
    LIST_SHORT,   // short list over a tiny pool: lots of repeats
    LIST_POOL,    // longer list over a wider pool: may run past a full table
    LIST_FILL,    // fills the table exactly, then pushes past it
    LIST_NOISE    // random values, last flag at random: ragged list ends
  } list_kind_e;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  sdf_in_if  in_ch();
  sdf_out_if out_ch();

  stream_distinct_filter #(
    .TABLE_DEPTH (SDF_TABLE_DEPTH),
    .VALUE_WIDTH (SDF_VALUE_WIDTH)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  int fail_count, pending, n_kept, n_dropped, n_overflow, n_lists;

  sdf_dedup_checker #(
    .TABLE_DEPTH (SDF_TABLE_DEPTH),
    .VALUE_WIDTH (SDF_VALUE_WIDTH)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_value      (in_ch.value),
    .in_last       (in_ch.last),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_value_out (out_ch.value_out),
    .out_keep      (out_ch.keep),
    .out_overflow  (out_ch.overflow),
    .out_last_out  (out_ch.last_out),
    .fail_count    (fail_count),
    .pending       (pending),
    .n_kept        (n_kept),
    .n_dropped     (n_dropped),
    .n_overflow    (n_overflow),
    .n_lists       (n_lists)
  );

  int   items_sent = 0;
  logic steady     = 1'b0;   // no idling on either side while set

  logic [SDF_DATA_W-1:0] pool[128];

  // One item on the input channel. Random gaps go in front of it; valid stays
  // high straight into the next item when no gap is drawn.
  task automatic send_item(input logic [SDF_DATA_W-1:0] v, input logic l);
    while (!steady && $urandom_range(0, 99) < 19) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= l;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    steady <= (items_sent >= STEADY_FROM && items_sent < STEADY_TO);
  endtask

  // Exactly DEPTH distinct values, then new values past the full table (each
  // sent twice: a value that could not be stored is kept again), mixed with
  // repeats of stored values.
  task automatic send_fill_list();
    logic [SDF_DATA_W-1:0] base, step, v;
    int                    extra;
    base  = $urandom;
    step  = $urandom | 32'd1;   // odd step keeps all DEPTH values distinct
    extra = $urandom_range(1, 4);
    for (int i = 0; i < DEPTH; i++) send_item(base + i * step, 1'b0);
    for (int i = 0; i < extra; i++) begin
      v = $urandom;
      send_item(v, 1'b0);
      send_item(v, 1'b0);
      send_item(base + $urandom_range(0, DEPTH - 1) * step, 1'b0);
    end
    // close with either a repeat or one more value that cannot be stored
    send_item($urandom_range(0, 1) ? base : $urandom, 1'b1);
  endtask

  // Result side: outside the steady window, ready drops at random with a chance of 19 in 100.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= steady || ($urandom_range(0, 99) >= 19);
    end
  end

  // Watchdog: a stuck handshake on either side ends the run.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 idle_cycles, pending);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    list_kind_e            kind;
    int                    len, pool_size, pick;
    logic [SDF_DATA_W-1:0] v;
    logic                  first_random;

    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    in_ch.last  <= 1'b0;
    rst_n       <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    // signed extremes, zero and -1, each repeated; list closes on a repeat
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hFFFF_FFFE, 1'b0);
    send_item(32'h0000_0000, 1'b1);
    // single-item lists back to back: the table must be empty for the second
    send_item(32'h5555_5555, 1'b1);
    send_item(32'h5555_5555, 1'b1);
    // a value from an earlier list counts as new again
    send_item(32'hAAAA_AAAA, 1'b0);
    send_item(32'h5555_5555, 1'b0);
    send_item(32'hAAAA_AAAA, 1'b0);
    send_item(32'h5555_5555, 1'b1);
    // list that ends on a new value
    send_item(32'h1234_5678, 1'b0);
    send_item(32'h8765_4321, 1'b1);

    // --- random lists ---
    first_random = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (first_random)  kind = LIST_FILL;   // make sure the full table is hit early
      else if (pick < 4) kind = LIST_SHORT;
      else if (pick < 7) kind = LIST_POOL;
      else if (pick < 8) kind = LIST_FILL;
      else               kind = LIST_NOISE;
      first_random = 1'b0;

      case (kind)
        LIST_SHORT: begin
          pool[0] = $urandom;
          pool[1] = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
          pool[2] = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
          pool[3] = $urandom;
          len = $urandom_range(1, 12);
          for (int i = 0; i < len; i++)
            send_item(pool[$urandom_range(0, 3)], i == len - 1);
        end
        LIST_POOL: begin
          pool_size = $urandom_range(8, 90);
          for (int i = 0; i < pool_size; i++) pool[i] = $urandom;
          len = $urandom_range(10, 120);
          for (int i = 0; i < len; i++)
            send_item(pool[$urandom_range(0, pool_size - 1)], i == len - 1);
        end
        LIST_FILL: begin
          send_fill_list();
        end
        default: begin
          // noise: fully random values, list may end anywhere or run on
          len = $urandom_range(1, 20);
          for (int i = 0; i < len; i++) begin
            v = $urandom;
            send_item(v, $urandom_range(0, 7) == 0);
          end
        end
      endcase
    end
    in_ch.valid <= 1'b0;

    // drain, then give the block time to show any stray result
    while (pending != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    $display("covered %0d items over %0d closed lists", items_sent, n_lists);
    $display("results: %0d kept, %0d dropped, %0d kept past a full table",
             n_kept, n_dropped, n_overflow);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: stream_distinct_filter.f
rtl/sdf_pkg.sv
rtl/sdf_in_if.sv
rtl/sdf_out_if.sv
rtl/sdf_seen_ram.sv
rtl/stream_distinct_filter.sv
bench/sdf_dedup_checker.sv
bench/testbench.sv
